/* hw/rtl/afp_pkg.sv */
`timescale 1ns / 1ps

package afp_pkg;

   // raw samples per key line and the samples that take part in the debounce
   localparam int DEBOUNCE_SAMPLES = 4;
   localparam logic [3:0] KEY_MASK = 4'((1 << DEBOUNCE_SAMPLES) - 1);

   // speed level bounds
   localparam logic [2:0] LEVEL_MIN = 3'd1;
   localparam logic [2:0] LEVEL_MED = 3'd3;
   localparam logic [2:0] LEVEL_MAX = 3'd5;

   // request kinds carried in tuser
   localparam logic CMD_TICK    = 1'b0;
   localparam logic CMD_POWERUP = 1'b1;

   // position in the shoot / reload loop
   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_SHOOT  = 2'd1,
      PH_RELOAD = 2'd2
   } phase_type;

   typedef struct packed {
      logic       enable;
      logic [2:0] level;
      phase_type  phase;
      logic [6:0] remaining;
   } state_type;

   typedef struct packed {
      logic       fire_drive;
      logic       led_on;
      logic       autofire_active;
      logic [2:0] speed_level;
      logic       corrupt;
   } result_type;

   // shoot half length in ticks, levels out of range use the normal speed
   function automatic logic [6:0] shoot_len(input logic [2:0] lvl);
      logic [6:0] len;
      case (lvl)
         3'd1:    len = 7'd20;
         3'd2:    len = 7'd20;
         3'd4:    len = 7'd3;
         3'd5:    len = 7'd2;
         default: len = 7'd7;
      endcase
      return len;
   endfunction

   // reload half length in ticks
   function automatic logic [6:0] reload_len(input logic [2:0] lvl);
      logic [6:0] len;
      case (lvl)
         3'd1:    len = 7'd108;
         3'd2:    len = 7'd30;
         3'd4:    len = 7'd3;
         3'd5:    len = 7'd2;
         default: len = 7'd7;
      endcase
      return len;
   endfunction

endpackage

/* hw/rtl/afp_update.sv */
`timescale 1ns / 1ps

module afp_update (
   input  logic                  cmd,
   input  logic [3:0]            start_samples,
   input  logic [3:0]            stop_samples,
   input  afp_pkg::state_type    state_cur,
   output afp_pkg::state_type    state_nxt,
   output afp_pkg::result_type   result
);

   logic               start_key;
   logic               stop_key;
   afp_pkg::phase_type ph;
   logic [6:0]         rem;
   logic [2:0]         lvl;
   logic               en;
   logic               fire;
   logic               corrupt;

   // debounce: a key is pressed only when every sample is low
   assign start_key = (start_samples & afp_pkg::KEY_MASK) == 4'd0;
   assign stop_key  = (stop_samples & afp_pkg::KEY_MASK) == 4'd0;

   // one step of the autofire loop or a power-up level adjust
   always_comb begin
      ph      = state_cur.phase;
      rem     = state_cur.remaining;
      lvl     = state_cur.level;
      en      = state_cur.enable;
      fire    = 1'b0;
      corrupt = 1'b0;
      if (cmd == afp_pkg::CMD_POWERUP) begin
         en  = 1'b0;
         ph  = afp_pkg::PH_IDLE;
         rem = 7'd0;
         if (stop_key && lvl > afp_pkg::LEVEL_MIN) begin
            lvl = lvl - 3'd1;
         end
         if (start_key && lvl < afp_pkg::LEVEL_MAX) begin
            lvl = lvl + 3'd1;
         end
         if (lvl > afp_pkg::LEVEL_MAX || lvl < afp_pkg::LEVEL_MIN) begin
            lvl     = afp_pkg::LEVEL_MED;
            corrupt = 1'b1;
         end
      end else begin
         // unused phase code behaves as loop top
         case (state_cur.phase)
            afp_pkg::PH_SHOOT:  ph = afp_pkg::PH_SHOOT;
            afp_pkg::PH_RELOAD: ph = afp_pkg::PH_RELOAD;
            default:            ph = afp_pkg::PH_IDLE;
         endcase
         // loop top with autofire on starts a shoot half
         if (ph == afp_pkg::PH_IDLE && state_cur.enable) begin
            ph  = afp_pkg::PH_SHOOT;
            rem = afp_pkg::shoot_len(lvl);
         end
         fire = (ph == afp_pkg::PH_SHOOT);
         // key poll, stop wins
         if (start_key) begin
            en = 1'b1;
         end
         if (stop_key) begin
            en = 1'b0;
         end
         // count down the running half
         if (ph != afp_pkg::PH_IDLE) begin
            if (rem != 7'd0) begin
               rem = rem - 7'd1;
            end
            if (rem == 7'd0) begin
               if (ph == afp_pkg::PH_SHOOT) begin
                  ph  = afp_pkg::PH_RELOAD;
                  rem = afp_pkg::reload_len(lvl);
               end else begin
                  ph = afp_pkg::PH_IDLE;
               end
            end
         end
      end
   end

   assign state_nxt.enable    = en;
   assign state_nxt.level     = lvl;
   assign state_nxt.phase     = ph;
   assign state_nxt.remaining = rem;

   assign result.fire_drive      = fire;
   assign result.led_on          = fire;
   assign result.autofire_active = en;
   assign result.speed_level     = lvl;
   assign result.corrupt         = corrupt;

endmodule

/* hw/rtl/autofire_pulse_generator_core.sv */
`timescale 1ns / 1ps
// channel | direction | tdata (low bit up)                         | tuser
// req_*   | in        | start_samples[3:0], stop_samples[7:4]      | cmd
// rsp_*   | out       | fire_drive, led_on, autofire_active,       | -
//         |           | speed_level[5:3], corrupt, zero pad        |
// a response becomes valid once its request has passed from the request register
// through the update logic into the response register.
// one request per cycle is sustained while responses are taken; the loop state
// updates as a request moves from the request to the response register.
// reset is synchronous: autofire off, level 3, loop top, both registers empty.
// a stalled response holds the request register; a new request is still taken
// whenever the request register empties in the same cycle.

module autofire_pulse_generator_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // start_samples[3:0], stop_samples[7:4]
   input  logic       req_tuser,   // cmd
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // fire_drive, led_on, autofire_active,
                                   // speed_level[5:3], corrupt, 0
);

   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic                 in_cmd_ff;
   logic [3:0]           in_start_ff;
   logic [3:0]           in_stop_ff;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   afp_pkg::result_type  out_data_ff;
   afp_pkg::state_type   state_ff;
   afp_pkg::state_type   state_in;
   afp_pkg::result_type  result;
   logic                 advance;

   // move a request forward when the response register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = advance ? 1'b1 : (out_valid_ff && !rsp_tready);

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_tvalid && req_tready) begin
         in_cmd_ff   <= req_tuser;
         in_start_ff <= req_tdata[3:0];
         in_stop_ff  <= req_tdata[7:4];
      end
   end

   afp_update u_update (
      .cmd           (in_cmd_ff),
      .start_samples (in_start_ff),
      .stop_samples  (in_stop_ff),
      .state_cur     (state_ff),
      .state_nxt     (state_in),
      .result        (result)
   );

   // loop state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff       <= 1'b0;
         state_ff.enable    <= 1'b0;
         state_ff.level     <= afp_pkg::LEVEL_MED;
         state_ff.phase     <= afp_pkg::PH_IDLE;
         state_ff.remaining <= 7'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_data_ff.corrupt, out_data_ff.speed_level,
                        out_data_ff.autofire_active, out_data_ff.led_on,
                        out_data_ff.fire_drive};

   // loop top exactly when no ticks are left to count
   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == afp_pkg::PH_IDLE) == (state_ff.remaining == 7'd0))
      else $error("phase and remaining count disagree");

   // level stays in its legal range
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.level >= afp_pkg::LEVEL_MIN && state_ff.level <= afp_pkg::LEVEL_MAX)
      else $error("speed level out of range");

   // power-up leaves autofire off at loop top
   a_powerup: assert property (@(posedge clock) disable iff (reset)
      advance && in_cmd_ff == afp_pkg::CMD_POWERUP |=>
      !state_ff.enable && state_ff.phase == afp_pkg::PH_IDLE && !out_data_ff.fire_drive)
      else $error("power-up did not stop autofire");

   // a fire tick is only ever produced from a tick request
   a_fire_tick: assert property (@(posedge clock) disable iff (reset)
      advance && result.fire_drive |-> in_cmd_ff == afp_pkg::CMD_TICK && !result.corrupt)
      else $error("fire pulse from a power-up request");

endmodule
